>>> rtl/alternating_press_rate_meter_top_assert.svh
// Assertion macros for the alternating press rate meter
`ifndef ALTERNATING_PRESS_RATE_METER_TOP_ASSERT_SVH
`define ALTERNATING_PRESS_RATE_METER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define APRM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("aprm assertion failed");
`define APRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aprm assertion failed");
`define APRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aprm assertion failed");
`else
`define APRM_ASSERT(lbl, cond)
`define APRM_ASSERT_IMP(lbl, ante, cons)
`define APRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/aprm_pkg.sv
// Constants shared by the alternating press rate meter
`timescale 1ns / 1ps
package aprm_pkg;
    localparam int TIME_WIDTH = 63;
    localparam int WIN_W      = 40;
    localparam int UNIT_W     = (TIME_WIDTH > WIN_W) ? TIME_WIDTH : WIN_W;
    localparam int STEP_W     = $clog2(WIN_W + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd10000000000;

    localparam logic [1:0] REQ_PRESS_A = 2'd0;
    localparam logic [1:0] REQ_PRESS_B = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    localparam logic [1:0] PRESS_MAX   = 2'd2;
endpackage

>>> rtl/aprm_if.sv
// Request, response and window write channels of the rate meter
`timescale 1ns / 1ps
interface aprm_req_if;
    import aprm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [TIME_WIDTH-1:0] event_time;
    modport source (output valid, output req_type, output event_time, input ready);
    modport sink   (input valid, input req_type, input event_time, output ready);
endinterface

interface aprm_rsp_if;
    import aprm_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] rate;
    logic             press_taken;
    modport source (output valid, output rate, output press_taken, input ready);
    modport sink   (input valid, input rate, input press_taken, output ready);
endinterface

interface aprm_cfg_if;
    import aprm_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_ns;
    modport source (output valid, output window_ns, input ready);
    modport sink   (input valid, input window_ns, output ready);
endinterface

>>> rtl/alternating_press_rate_meter_top.sv
// Top level of the alternating press rate meter
//
//   port  dir  content
//   req   in   req_type, event_time
//   rsp   out  rate, press_taken
//   cfg   in   window_ns
//
// A press, an unused code or a query with fewer than two presses goes from accept straight to the response.
// A query runs accept, up to four setup steps, 40 divider steps and the response;
// it ends early when the gap or the window check gives 0.
// One subtractor serves the gap, elapsed time, compare and divide steps.
// req.ready is high only in idle; a stalled response keeps the block out of idle.
// Reset sets the window to 10 s and clears presses; cfg is always ready.
`timescale 1ns / 1ps
module alternating_press_rate_meter_top (
    input  logic           clk,
    input  logic           rst_n,
    aprm_req_if.sink       req,
    aprm_rsp_if.source     rsp,
    aprm_cfg_if.sink       cfg
);
    import aprm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_GAP   = 7'b0000010,
        S_SINCE = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_WIN   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [TIME_WIDTH-1:0] prev_reg, prev_next;
    logic [1:0]            presses_reg, presses_next;
    logic                  expect_b_reg, expect_b_next;
    logic [WIN_W-1:0]      window_reg, window_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [UNIT_W-1:0]     period_reg, period_next;
    logic [UNIT_W-1:0]     since_reg, since_next;
    logic [WIN_W-1:0]      rem_reg, rem_next;
    logic [WIN_W-1:0]      num_reg, num_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [WIN_W-1:0]      rate_reg, rate_next;
    logic                  taken_reg, taken_next;

    logic [UNIT_W:0]       sub_a, sub_b;
    logic [UNIT_W+1:0]     sub_diff;
    logic                  sub_borrow;
    logic                  sub_zero;
    logic [WIN_W:0]        rem_shift;
    logic                  req_fire;
    logic                  press_ok;

    assign req.ready   = (state_reg == S_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign press_ok    = (req.req_type == REQ_PRESS_A || req.req_type == REQ_PRESS_B)
                         && ((req.req_type == REQ_PRESS_B) == expect_b_reg);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = (state_reg == S_OUT);
    assign rsp.rate    = rate_reg;
    assign rsp.press_taken = taken_reg;

    assign rem_shift = {rem_reg, num_reg[WIN_W-1]};

    always_comb
    begin
        unique case (state_reg)
            S_GAP:
            begin
                sub_a = {{(UNIT_W+1-TIME_WIDTH){1'b0}}, last_reg};
                sub_b = {{(UNIT_W+1-TIME_WIDTH){1'b0}}, prev_reg};
            end
            S_SINCE:
            begin
                sub_a = {{(UNIT_W+1-TIME_WIDTH){1'b0}}, now_reg};
                sub_b = {{(UNIT_W+1-TIME_WIDTH){1'b0}}, last_reg};
            end
            S_PICK:
            begin
                sub_a = {1'b0, period_reg};
                sub_b = {1'b0, since_reg};
            end
            S_WIN:
            begin
                sub_a = {1'b0, period_reg};
                sub_b = {{(UNIT_W+1-WIN_W){1'b0}}, window_reg};
            end
            S_DIV:
            begin
                sub_a = {{(UNIT_W-WIN_W){1'b0}}, rem_shift};
                sub_b = {1'b0, period_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[UNIT_W+1];
    assign sub_zero   = (sub_diff[UNIT_W:0] == '0);

    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        prev_next     = prev_reg;
        presses_next  = presses_reg;
        expect_b_next = expect_b_reg;
        window_next   = window_reg;
        now_next      = now_reg;
        period_next   = period_reg;
        since_next    = since_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        step_next     = step_reg;
        rate_next     = rate_reg;
        taken_next    = taken_reg;

        if (cfg.valid && cfg.ready)
        begin
            window_next = cfg.window_ns;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rate_next  = '0;
                    taken_next = 1'b0;
                    now_next   = req.event_time;
                    state_next = S_OUT;
                    if (press_ok)
                    begin
                        expect_b_next = !expect_b_reg;
                        prev_next     = last_reg;
                        last_next     = req.event_time;
                        taken_next    = 1'b1;
                        if (presses_reg != PRESS_MAX)
                        begin
                            presses_next = presses_reg + 2'd1;
                        end
                    end
                    else if (req.req_type == REQ_QUERY && presses_reg == PRESS_MAX)
                    begin
                        state_next = S_GAP;
                    end
                end
            end
            S_GAP:
            begin
                period_next = sub_diff[UNIT_W-1:0];
                state_next  = (sub_borrow || sub_zero) ? S_OUT : S_SINCE;
            end
            S_SINCE:
            begin
                since_next = sub_diff[UNIT_W-1:0];
                state_next = sub_borrow ? S_WIN : S_PICK;
            end
            S_PICK:
            begin
                if (sub_borrow)
                begin
                    period_next = since_reg;
                end
                state_next = S_WIN;
            end
            S_WIN:
            begin
                rem_next  = '0;
                num_next  = window_reg;
                step_next = STEP_W'(WIN_W);
                state_next = sub_borrow ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                rem_next  = sub_borrow ? rem_shift[WIN_W-1:0] : sub_diff[WIN_W-1:0];
                num_next  = {num_reg[WIN_W-2:0], !sub_borrow};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    rate_next  = {num_reg[WIN_W-2:0], !sub_borrow};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_reg     <= '0;
            prev_reg     <= '0;
            presses_reg  <= '0;
            expect_b_reg <= 1'b0;
            window_reg   <= WINDOW_RESET;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            prev_reg     <= prev_next;
            presses_reg  <= presses_next;
            expect_b_reg <= expect_b_next;
            window_reg   <= window_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        period_reg <= period_next;
        since_reg  <= since_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        rate_reg   <= rate_next;
        taken_reg  <= taken_next;
    end

`include "alternating_press_rate_meter_top_assert.svh"

    `APRM_ASSERT(a_presses_sat, presses_reg <= PRESS_MAX)
    `APRM_ASSERT_IMP(a_div_step, state_reg == S_DIV, step_reg != '0)
    `APRM_ASSERT_IMP(a_div_period, state_reg == S_DIV, period_reg != '0)
    `APRM_ASSERT_NEXT(a_press_rsp, req_fire && press_ok, rsp.valid && rsp.press_taken && rsp.rate == '0)
    `APRM_ASSERT_NEXT(a_press_flip, req_fire && press_ok, expect_b_reg != $past(expect_b_reg))

endmodule
